// ----- sv/nrf_pkg.sv -----
// Shared types and constants for the nonce replay filter.
// Used by nrf_ctrl, nrf_datapath, nonce_replay_filter and the testbench; depends on nothing.
package nrf_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam int unsigned TS_ROUNDS = 8;

	typedef enum logic [1:0] {
		V_ACCEPT        = 2'd0,
		V_MISSING_TS    = 2'd1,
		V_MISSING_NONCE = 2'd2,
		V_REPLAY        = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BYTE,
		S_TS,
		S_SEARCH,
		S_DRAIN,
		S_DECIDE,
		S_FIN
	} state_t;

	typedef struct packed {
		logic latch;     // capture the accepted input beat
		logic mix_byte;  // hash in the captured nonce byte
		logic mix_ts;    // hash in the next timestamp byte
		logic rd;        // read the ring entry at the counter
		logic commit;    // store the hash and advance the write pointer
		logic load_out;  // load the result register and end the message
	} cmd_t;

	typedef struct packed {
		logic last;
		logic require;
		logic ts_zero;
		logic seen;
		logic hit;
		logic ts_done;
		logic rd_done;
		logic out_free;
	} status_t;

	// FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a sum of shifts.
	function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

// ----- sv/nrf_ctrl.sv -----
// Controller state machine of the nonce replay filter.
// Depends on nrf_pkg for the state, command and status types.
module nrf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  nrf_pkg::status_t sts,
	output nrf_pkg::cmd_t    cmd
);
	import nrf_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_BYTE;
				end
			end
			S_BYTE: begin
				state_nxt = sts.last ? S_TS : S_IDLE;
			end
			S_TS: begin
				if (sts.ts_done) begin
					// Only a signed message with a timestamp and a nonce is looked up.
					if (sts.require && !sts.ts_zero && sts.seen) begin
						state_nxt = S_SEARCH;
					end else begin
						state_nxt = S_FIN;
					end
				end
			end
			S_SEARCH: begin
				if (sts.rd_done) begin
					state_nxt = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				state_nxt = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall  = 1'b0;
				cmd.latch = in_valid;
			end
			S_BYTE: begin
				cmd.mix_byte = 1'b1;
			end
			S_TS: begin
				cmd.mix_ts = 1'b1;
			end
			S_SEARCH: begin
				cmd.rd = 1'b1;
			end
			S_DRAIN: begin
				cmd = '0;
			end
			S_DECIDE: begin
				cmd.commit = !sts.hit;
			end
			S_FIN: begin
				cmd.load_out = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- sv/nrf_datapath.sv -----
// Datapath of the nonce replay filter: hash register, timestamp rounds,
// replay rings, configuration register and result register. Depends on nrf_pkg.
module nrf_datapath #(
	parameter int RING_DEPTH = 16,
	parameter int RING_COUNT = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  nrf_pkg::cmd_t    cmd,
	output nrf_pkg::status_t sts,
	input  logic [7:0]       nonce_byte,
	input  logic             byte_valid,
	input  logic             last_byte,
	input  logic [63:0]      timestamp,
	input  logic             cache_select,
	input  logic             cfg_we,
	input  logic             cfg_require,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       verdict,
	output logic [63:0]      nonce_hash
);
	import nrf_pkg::*;

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int SEL_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
	localparam int CNT_W = (PTR_W > 3) ? PTR_W : 3;

	logic [63:0] mem [RING_COUNT][RING_DEPTH];

	logic [63:0]      hash_q;
	logic             seen_q;
	logic             require_q;
	logic [7:0]       byte_q;
	logic             bvalid_q;
	logic             last_q;
	logic [63:0]      ts_q;
	logic             ts_zero_q;
	logic [SEL_W-1:0] sel_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit_q;
	logic [PTR_W-1:0] wp_q [RING_COUNT];
	logic             full_q [RING_COUNT];

	logic             rd_vld_s1;
	logic [PTR_W-1:0] rd_idx_s1;
	logic [63:0]      rdata_s1;

	logic             out_valid_q;
	verdict_t         verdict_q;
	logic [63:0]      out_hash_q;

	logic             ts_done;
	logic             rd_done;
	logic             cnt_end;
	logic             out_free;
	logic             entry_live;
	logic [SEL_W-1:0] sel_in;
	verdict_t         verdict_nxt;

	assign ts_done  = (cnt_q == CNT_W'(TS_ROUNDS - 1));
	assign rd_done  = (cnt_q == CNT_W'(RING_DEPTH - 1));
	assign cnt_end  = (cmd.mix_ts && ts_done) || (cmd.rd && rd_done);
	assign out_free = !out_valid_q || !out_stall;
	assign sel_in   = (RING_COUNT > 1) ? SEL_W'(cache_select) : '0;

	// Entries past the write pointer of a ring that has not yet wrapped hold no
	// stored hash and are masked out by entry_live, so they cannot match.
	assign entry_live = full_q[sel_q] || (rd_idx_s1 < wp_q[sel_q]);

	always_comb begin
		if (!require_q) begin
			verdict_nxt = V_ACCEPT;
		end else if (ts_zero_q) begin
			verdict_nxt = V_MISSING_TS;
		end else if (!seen_q) begin
			verdict_nxt = V_MISSING_NONCE;
		end else if (hit_q) begin
			verdict_nxt = V_REPLAY;
		end else begin
			verdict_nxt = V_ACCEPT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q      <= FNV_BASIS;
			seen_q      <= 1'b0;
			require_q   <= 1'b1;
			cnt_q       <= '0;
			hit_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int r = 0; r < RING_COUNT; r++) begin
				wp_q[r]   <= '0;
				full_q[r] <= 1'b0;
			end
		end else begin
			if (cfg_we) begin
				require_q <= cfg_require;
			end

			if (cmd.mix_ts || cmd.rd) begin
				cnt_q <= cnt_end ? '0 : cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end

			if (cmd.mix_byte && bvalid_q) begin
				hash_q <= fnv_mix(hash_q, byte_q);
				seen_q <= 1'b1;
			end else if (cmd.mix_ts) begin
				hash_q <= fnv_mix(hash_q, ts_q[7:0]);
			end else if (cmd.load_out) begin
				hash_q <= FNV_BASIS;
				seen_q <= 1'b0;
			end

			rd_vld_s1 <= cmd.rd;
			if (cmd.latch) begin
				hit_q <= 1'b0;
			end else if (rd_vld_s1 && entry_live && (rdata_s1 != '0) && (rdata_s1 == hash_q)) begin
				hit_q <= 1'b1;
			end

			if (cmd.commit) begin
				if (wp_q[sel_q] == PTR_W'(RING_DEPTH - 1)) begin
					wp_q[sel_q]   <= '0;
					full_q[sel_q] <= 1'b1;
				end else begin
					wp_q[sel_q] <= wp_q[sel_q] + PTR_W'(1);
				end
			end

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured beat and the timestamp shifter; these need no reset.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q    <= nonce_byte;
			bvalid_q  <= byte_valid;
			last_q    <= last_byte;
			ts_q      <= timestamp;
			ts_zero_q <= (timestamp == '0);
			sel_q     <= sel_in;
		end else if (cmd.mix_ts) begin
			ts_q <= ts_q >> 8;
		end
		if (cmd.load_out) begin
			verdict_q  <= verdict_nxt;
			out_hash_q <= hash_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			mem[sel_q][wp_q[sel_q]] <= hash_q;
		end
		if (cmd.rd) begin
			rdata_s1 <= mem[sel_q][cnt_q[PTR_W-1:0]];
			rd_idx_s1 <= cnt_q[PTR_W-1:0];
		end
	end

	always_comb begin
		sts          = '0;
		sts.last     = last_q;
		sts.require  = require_q;
		sts.ts_zero  = ts_zero_q;
		sts.seen     = seen_q;
		sts.hit      = hit_q;
		sts.ts_done  = ts_done;
		sts.rd_done  = rd_done;
		sts.out_free = out_free;
	end

	assign out_valid  = out_valid_q;
	assign verdict    = verdict_q;
	assign nonce_hash = out_hash_q;

endmodule

// ----- sv/nonce_replay_filter.sv -----
// Top level of the nonce replay filter: FNV-1a 64 hash of nonce and timestamp
// with replay rings. Instantiates nrf_ctrl and nrf_datapath; depends on nrf_pkg.
//
//   Channel  Handshake             Beat carries
//   -------  --------------------  ------------------------------------------------
//   in       in_valid / in_stall   nonce_byte, byte_valid, last_byte, timestamp,
//                                  cache_select
//   out      out_valid / out_stall verdict, nonce_hash (one beat per message)
//   cfg      cfg_valid / cfg_ready require_signed
//
// A beat that is not last is captured, then hashed in one round. A last beat
// adds eight timestamp rounds and a load of the result register. A signed
// message with a timestamp and a nonce also scans its ring, reading its entries
// in turn since the ring memory has a single read port, then drains the last
// read and decides, storing the new hash only if it is not a replay.
// The result register frees the input side; a further message waits only at
// its end while a previous result is still held by out_stall.
// Reset clears the rings logically through per-ring write pointers and wrap
// flags, so no clearing pass is needed and the block is ready at once.
module nonce_replay_filter #(
	parameter int RING_DEPTH = 16,
	parameter int RING_COUNT = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  nonce_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	input  logic [63:0] timestamp,
	input  logic        cache_select,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  verdict,
	output logic [63:0] nonce_hash,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        require_signed
);
	import nrf_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	nrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	nrf_datapath #(
		.RING_DEPTH (RING_DEPTH),
		.RING_COUNT (RING_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.nonce_byte   (nonce_byte),
		.byte_valid   (byte_valid),
		.last_byte    (last_byte),
		.timestamp    (timestamp),
		.cache_select (cache_select),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_require  (require_signed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.nonce_hash   (nonce_hash)
	);

endmodule

// ----- sim/nonce_replay_filter_tb.sv -----
// Self-checking testbench for nonce_replay_filter: random and directed nonce messages,
// with the expected verdict and hash worked out by a scoreboard and checked per beat.
// Depends on nrf_pkg and the nonce_replay_filter RTL.
module nonce_replay_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nrf_pkg::*;

	localparam int          DEPTH         = 16;
	localparam int          RINGS         = 2;
	localparam logic [63:0] MIX_MULT      = 64'd1099511628211;
	localparam int          TARGET_ITEMS  = 1200;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          LIMIT_CYCLES  = 400000;
	localparam int          POOL          = 24;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  nonce_byte;
	logic        byte_valid;
	logic        last_byte;
	logic [63:0] timestamp;
	logic        cache_select;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  verdict;
	logic [63:0] nonce_hash;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        require_signed;

	// Scoreboard: mirrors the hash, the replay rings and the signing mode, and
	// holds the verdict and hash expected for each message still in flight.
	class replay_scoreboard;
		bit          require_sig;
		logic [63:0] run_hash;
		bit          nonce_seen;
		logic [63:0] ring [RINGS][DEPTH];
		int unsigned wr_ptr [RINGS];
		verdict_t    want_verdict [$];
		logic [63:0] want_hash [$];
		int          errors;

		function new();
			require_sig = 1'b1;
			run_hash = FNV_BASIS;
			nonce_seen = 1'b0;
			errors = 0;
			foreach (ring[i, j]) ring[i][j] = '0;
			foreach (wr_ptr[i]) wr_ptr[i] = 0;
		endfunction

		function logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
			return (h ^ {56'd0, b}) * MIX_MULT;
		endfunction

		function int pending();
			return want_verdict.size();
		endfunction

		function void note_beat(logic [7:0] b, logic bv, logic last, logic [63:0] ts,
				logic sel);
			logic [63:0] h;
			verdict_t    v;
			bit          seen;
			bit          hit;
			int          r;
			if (bv) begin
				run_hash = fnv_step(run_hash, b);
				nonce_seen = 1'b1;
			end
			if (!last)
				return;
			h = run_hash;
			for (int i = 0; i < 8; i++)
				h = fnv_step(h, ts[i*8 +: 8]);
			seen = nonce_seen;
			run_hash = FNV_BASIS;
			nonce_seen = 1'b0;
			r = int'(sel) % RINGS;
			v = V_ACCEPT;
			if (require_sig) begin
				if (ts == '0) begin
					v = V_MISSING_TS;
				end else if (!seen) begin
					v = V_MISSING_NONCE;
				end else begin
					hit = 1'b0;
					for (int i = 0; i < DEPTH; i++)
						if (ring[r][i] != '0 && ring[r][i] == h)
							hit = 1'b1;
					if (hit) begin
						v = V_REPLAY;
					end else begin
						// Only a fresh hash takes a slot in the ring.
						ring[r][wr_ptr[r]] = h;
						wr_ptr[r] = (wr_ptr[r] + 1) % DEPTH;
					end
				end
			end
			want_verdict.push_back(v);
			want_hash.push_back(h);
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(logic [1:0] v, logic [63:0] h);
			verdict_t    wv;
			logic [63:0] wh;
			if (want_verdict.size() == 0) begin
				report($sformatf("result beat with no message pending (verdict %0d)", v));
				return;
			end
			wv = want_verdict.pop_front();
			wh = want_hash.pop_front();
			if (v !== wv)
				report($sformatf("verdict %0d, expected %s", v, wv.name()));
			if (h !== wh)
				report($sformatf("nonce_hash %h, expected %h", h, wh));
		endtask
	endclass

	replay_scoreboard sb;

	int          items_sent;
	int          cycle_count;
	int          sink_hold;
	bit          src_quiet;
	bit          sink_quiet;
	logic [7:0]  msg_buf [8];
	logic [7:0]  pool_bytes [POOL][8];
	int          pool_len [POOL];
	logic [63:0] pool_ts [POOL];
	logic        pool_sel [POOL];
	int          pool_fill;
	int          pool_next;

	nonce_replay_filter #(
		.RING_DEPTH (DEPTH),
		.RING_COUNT (RINGS)
	) u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.nonce_byte     (nonce_byte),
		.byte_valid     (byte_valid),
		.last_byte      (last_byte),
		.timestamp      (timestamp),
		.cache_select   (cache_select),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.nonce_hash     (nonce_hash),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.require_signed (require_signed)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: every accepted beat is checked, then a fresh stall length is drawn.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result(verdict, nonce_hash);
				sink_hold = sink_quiet ? 0 : $urandom_range(0, 16);
			end else if (sink_hold > 0) begin
				sink_hold--;
			end
			out_stall <= (sink_hold > 0);
		end
	end

	task automatic send_item(logic [7:0] b, logic bv, logic last, logic [63:0] ts,
			logic sel);
		int gap;
		gap = src_quiet ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		nonce_byte   <= b;
		byte_valid   <= bv;
		last_byte    <= last;
		timestamp    <= ts;
		cache_select <= sel;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b, bv, last, ts, sel);
		if (bv || last)
			items_sent++;
	endtask

	// Sends msg_buf[0 .. len-1] as one message. With noisy set, empty beats are
	// slipped in between bytes; with bare_end set the last beat carries no byte.
	task automatic send_message(int len, logic [63:0] ts, logic sel, bit noisy,
			bit bare_end);
		logic [7:0] junk;
		for (int i = 0; i < len; i++) begin
			junk = 8'($urandom_range(0, 255));
			if (noisy && $urandom_range(0, 3) == 0)
				send_item(junk, 1'b0, 1'b0, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
			if (i == len - 1 && !bare_end)
				send_item(msg_buf[i], 1'b1, 1'b1, ts, sel);
			else
				send_item(msg_buf[i], 1'b1, 1'b0, {$urandom, $urandom}, sel);
		end
		if (len == 0 || bare_end)
			send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, ts, sel);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_signing(logic v);
		cfg_valid      <= 1'b1;
		require_signed <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.require_sig = v;
	endtask

	task automatic random_message();
		int          r;
		int          len;
		int          k;
		logic [63:0] ts;
		logic        sel;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			src_quiet = ~src_quiet;
		if ($urandom_range(0, 9) == 0)
			sink_quiet = ~sink_quiet;
		if (r < 30 && pool_fill > 0) begin
			// Replay a recent message, now and then towards the other ring.
			k = $urandom_range(0, pool_fill - 1);
			len = pool_len[k];
			ts = pool_ts[k];
			sel = ($urandom_range(0, 4) == 0) ? ~pool_sel[k] : pool_sel[k];
			for (int i = 0; i < 8; i++)
				msg_buf[i] = pool_bytes[k][i];
		end else begin
			len = (r < 36) ? 0 : $urandom_range(1, 8);
			case ($urandom_range(0, 19))
				0: ts = '0;
				1: ts = '1;
				default: ts = {$urandom, $urandom};
			endcase
			sel = 1'($urandom_range(0, 1));
			for (int i = 0; i < 8; i++)
				msg_buf[i] = 8'($urandom_range(0, 255));
			pool_len[pool_next] = len;
			pool_ts[pool_next] = ts;
			pool_sel[pool_next] = sel;
			for (int i = 0; i < 8; i++)
				pool_bytes[pool_next][i] = msg_buf[i];
			pool_next = (pool_next + 1) % POOL;
			if (pool_fill < POOL)
				pool_fill++;
		end
		send_message(len, ts, sel, $urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
	endtask

	initial begin
		logic [63:0] ts_a;
		int          goal;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		nonce_byte = '0;
		byte_valid = 1'b0;
		last_byte = 1'b0;
		timestamp = '0;
		cache_select = 1'b0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		require_signed = 1'b1;
		items_sent = 0;
		cycle_count = 0;
		sink_hold = 0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		pool_fill = 0;
		pool_next = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with signing required as it is out of reset.
		ts_a = 64'h0000_0000_6500_1234;
		msg_buf[0] = 8'h61;
		msg_buf[1] = 8'h62;
		send_message(2, ts_a, 1'b0, 1'b0, 1'b0);
		send_message(2, ts_a, 1'b0, 1'b0, 1'b0);
		send_message(2, ts_a, 1'b1, 1'b0, 1'b0);
		send_message(2, '0, 1'b0, 1'b0, 1'b0);
		send_message(0, ts_a, 1'b0, 1'b0, 1'b0);
		send_message(0, '0, 1'b1, 1'b0, 1'b0);
		msg_buf[0] = 8'hFF;
		msg_buf[1] = 8'h00;
		msg_buf[2] = 8'h5A;
		send_message(3, 64'h1, 1'b1, 1'b1, 1'b1);
		send_message(2, '1, 1'b0, 1'b0, 1'b0);
		send_message(2, '1, 1'b0, 1'b0, 1'b0);
		settle();
		write_signing(1'b0);
		msg_buf[0] = 8'h61;
		msg_buf[1] = 8'h62;
		send_message(2, ts_a, 1'b0, 1'b0, 1'b0);
		send_message(2, '0, 1'b1, 1'b0, 1'b0);
		send_message(0, ts_a, 1'b0, 1'b0, 1'b0);
		settle();
		write_signing(1'b1);
		send_message(2, ts_a, 1'b0, 1'b0, 1'b0);

		// Random part in four phases, toggling the signing mode between them.
		for (int phase = 0; phase < 4; phase++) begin
			settle();
			write_signing(phase % 2 == 1 ? 1'b0 : 1'b1);
			goal = items_sent + TARGET_ITEMS / 4;
			while (items_sent < goal)
				random_message();
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- nonce_replay_filter.f -----
sv/nrf_pkg.sv
sv/nrf_ctrl.sv
sv/nrf_datapath.sv
sv/nonce_replay_filter.sv
sim/nonce_replay_filter_tb.sv
